// ===== sv/qwcs_pkg.sv =====
`default_nettype none

package qwcs_pkg;

	localparam int LOG_SIZE  = 6;
	localparam int RATE_BITS = 24;
	localparam int DRAW_BITS = 16;

	localparam int CELL_W    = 6;
	localparam int RATE_IN_W = 24;
	localparam int DRAW_IN_W = 64;
	localparam int TOTAL_W   = 36;
	localparam int SLOT_W    = 16;

	localparam int NODE_COUNT = ((1 << (2 * (LOG_SIZE + 1))) - 1) / 3;
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int LEV_W      = $clog2(LOG_SIZE + 1);
	localparam int COORD_W    = LOG_SIZE;
	localparam int SUM_W      = RATE_BITS + 2 * LOG_SIZE;
	localparam int ADD_W      = SUM_W + 1;
	localparam int CUM_W      = SUM_W + 2;
	localparam int SCALED_W   = SUM_W + DRAW_BITS;
	localparam int CMP_W      = CUM_W + DRAW_BITS;

	localparam logic [SUM_W-1:0] RATE_MAX = SUM_W'((64'd1 << RATE_BITS) - 64'd1);

	localparam logic [1:0] REQ_SET    = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [SUM_W-1:0]  wdata;
	} mem_cmd_t;

	function automatic logic [ADDR_W-1:0] level_base(input logic [LEV_W-1:0] lev);
		logic [ADDR_W-1:0] base;
		base = '0;
		for (int i = 0; i <= LOG_SIZE; i++) begin
			if (LEV_W'(i) < lev) begin
				base = base + ADDR_W'(64'd1 << (2 * i));
			end
		end
		return base;
	endfunction

	function automatic logic [ADDR_W-1:0] node_addr(input logic [LEV_W-1:0] lev,
			input logic [COORD_W-1:0] nx, input logic [COORD_W-1:0] ny);
		return level_base(lev) + ((ADDR_W'(ny) << lev) | ADDR_W'(nx));
	endfunction

endpackage

`default_nettype wire

// ===== sv/qwcs_req_if.sv =====
`default_nettype none

interface qwcs_req_if import qwcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [CELL_W-1:0]    cell_x;
	logic [CELL_W-1:0]    cell_y;
	logic [RATE_IN_W-1:0] new_rate;
	logic [DRAW_IN_W-1:0] draws_low;
	logic [DRAW_IN_W-1:0] draws_high;

	modport source (output valid, req_type, cell_x, cell_y, new_rate, draws_low, draws_high,
		input ready);
	modport sink (input valid, req_type, cell_x, cell_y, new_rate, draws_low, draws_high,
		output ready);
endinterface

`default_nettype wire

// ===== sv/qwcs_rsp_if.sv =====
`default_nettype none

interface qwcs_rsp_if import qwcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [RATE_IN_W-1:0] cell_rate;
	logic [CELL_W-1:0]    picked_x;
	logic [CELL_W-1:0]    picked_y;
	logic [TOTAL_W-1:0]   total_rate;

	modport source (output valid, cell_rate, picked_x, picked_y, total_rate, input ready);
	modport sink (input valid, cell_rate, picked_x, picked_y, total_rate, output ready);
endinterface

`default_nettype wire

// ===== sv/qwcs_node_mem.sv =====
`default_nettype none

module qwcs_node_mem import qwcs_pkg::*; (
	input  wire logic             clk,
	input  wire mem_cmd_t         cmd,
	output      logic [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				mem[cmd.addr] <= cmd.wdata;
			end else begin
				rdata <= mem[cmd.addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/quadtree_weighted_cell_sampler_top.sv =====
`default_nettype none

// Weighted cell sampler over a 64x64 grid. A quadtree of rate sums (5461 nodes of 36 bits)
// sits in one single-port memory, and every request is worked by a small sequencer that
// reads or writes one node per cycle, so one item is taken at a time and ready is low while
// it runs. After reset a clearing pass zeroes every node before the first item is taken.
// A set reads the old leaf, then reads, adds and writes back each of the 7 levels; a read
// fetches the leaf; a sample, for each of the 6 levels, does one 16x36 multiply and then
// reads and compares each child visited, one to four children. A finished result waits
// in the output register while the next item is taken.
module quadtree_weighted_cell_sampler_top import qwcs_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	qwcs_req_if.sink   req,
	qwcs_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SET_LEAF, S_SET_OLD, S_SET_RD, S_SET_ADD, S_SET_WR,
		S_RD_ISSUE, S_RD_GET, S_SMP_MUL, S_SMP_RD, S_SMP_CMP, S_DONE
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       clr_q;
	logic [1:0]              type_q;
	logic [COORD_W-1:0]      x_q, y_q;
	logic [RATE_BITS-1:0]    rate_q;
	logic [2*DRAW_IN_W-1:0]  draws_q;
	logic [LEV_W-1:0]        lev_q;
	logic [SUM_W-1:0]        old_q;
	logic [ADD_W-1:0]        t_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SCALED_W-1:0]     scaled_q;
	logic [CUM_W-1:0]        cum_q;
	logic [1:0]              c_q;
	logic [COORD_W-1:0]      px_q, py_q;
	logic [RATE_IN_W-1:0]    cell_rate_q;
	logic [TOTAL_W-1:0]      total_q;
	logic                    out_valid_q;
	logic [RATE_IN_W-1:0]    out_rate_q;
	logic [CELL_W-1:0]       out_x_q, out_y_q;
	logic [TOTAL_W-1:0]      out_total_q;

	mem_cmd_t                mem_cmd;
	logic [SUM_W-1:0]        rdata;
	logic [LEV_W-1:0]        shift;
	logic [ADDR_W-1:0]       set_addr;
	logic [ADDR_W-1:0]       leaf_addr;
	logic [ADDR_W-1:0]       child_addr;
	logic [SUM_W-1:0]        upd;
	logic [CUM_W-1:0]        cum_n;
	logic                    hit;
	logic [DRAW_BITS-1:0]    draw;

	qwcs_node_mem u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (rdata)
	);

	assign shift      = LEV_W'(LOG_SIZE) - lev_q;
	assign set_addr   = node_addr(lev_q, x_q >> shift, y_q >> shift);
	assign leaf_addr  = node_addr(LEV_W'(LOG_SIZE), x_q, y_q);
	assign child_addr = node_addr(lev_q + LEV_W'(1), COORD_W'({px_q, c_q[0]}),
		COORD_W'({py_q, c_q[1]}));
	assign upd        = (t_q >= ADD_W'(old_q)) ? SUM_W'(t_q - ADD_W'(old_q)) : '0;
	assign cum_n      = cum_q + CUM_W'(rdata);
	assign hit        = ({cum_n, {DRAW_BITS{1'b0}}} > CMP_W'(scaled_q)) || (c_q == 2'd3);
	assign draw       = draws_q[DRAW_BITS-1:0];

	always_comb begin
		mem_cmd = '0;
		case (state_q)
			S_CLR: begin
				mem_cmd.en   = 1'b1;
				mem_cmd.we   = 1'b1;
				mem_cmd.addr = clr_q;
			end
			S_SET_LEAF, S_RD_ISSUE: begin
				mem_cmd.en   = 1'b1;
				mem_cmd.addr = leaf_addr;
			end
			S_SET_RD: begin
				mem_cmd.en   = 1'b1;
				mem_cmd.addr = set_addr;
			end
			S_SET_WR: begin
				mem_cmd.en    = 1'b1;
				mem_cmd.we    = 1'b1;
				mem_cmd.addr  = set_addr;
				mem_cmd.wdata = upd;
			end
			S_SMP_RD: begin
				mem_cmd.en   = 1'b1;
				mem_cmd.addr = child_addr;
			end
			default: begin
				mem_cmd = '0;
			end
		endcase
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.cell_rate  = out_rate_q;
	assign rsp.picked_x   = out_x_q;
	assign rsp.picked_y   = out_y_q;
	assign rsp.total_rate = out_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			lev_q       <= '0;
			c_q         <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (mem_cmd.we && mem_cmd.addr == '0) begin
				total_q <= TOTAL_W'(mem_cmd.wdata);
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						type_q      <= req.req_type;
						x_q         <= COORD_W'(req.cell_x);
						y_q         <= COORD_W'(req.cell_y);
						rate_q      <= (SUM_W'(req.new_rate) > RATE_MAX) ?
							RATE_BITS'(RATE_MAX) : RATE_BITS'(req.new_rate);
						draws_q     <= {req.draws_high, req.draws_low};
						lev_q       <= '0;
						c_q         <= '0;
						cum_q       <= '0;
						px_q        <= '0;
						py_q        <= '0;
						cell_rate_q <= '0;
						sum_q       <= SUM_W'(total_q);
						case (req.req_type)
							REQ_SET:    state_q <= S_SET_LEAF;
							REQ_READ:   state_q <= S_RD_ISSUE;
							REQ_SAMPLE: state_q <= S_SMP_MUL;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_SET_LEAF: begin
					state_q <= S_SET_OLD;
				end
				S_SET_OLD: begin
					old_q   <= rdata;
					state_q <= S_SET_RD;
				end
				S_SET_RD: begin
					state_q <= S_SET_ADD;
				end
				S_SET_ADD: begin
					t_q     <= ADD_W'(rdata) + ADD_W'(rate_q);
					state_q <= S_SET_WR;
				end
				S_SET_WR: begin
					if (lev_q == LEV_W'(LOG_SIZE)) begin
						state_q <= S_DONE;
					end else begin
						lev_q   <= lev_q + LEV_W'(1);
						state_q <= S_SET_RD;
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_GET;
				end
				S_RD_GET: begin
					cell_rate_q <= RATE_IN_W'(rdata);
					state_q     <= S_DONE;
				end
				S_SMP_MUL: begin
					scaled_q <= SCALED_W'(draw) * SCALED_W'(sum_q);
					cum_q    <= '0;
					c_q      <= '0;
					state_q  <= S_SMP_RD;
				end
				S_SMP_RD: begin
					state_q <= S_SMP_CMP;
				end
				S_SMP_CMP: begin
					if (hit) begin
						px_q    <= COORD_W'({px_q, c_q[0]});
						py_q    <= COORD_W'({py_q, c_q[1]});
						sum_q   <= rdata;
						draws_q <= draws_q >> SLOT_W;
						if (lev_q == LEV_W'(LOG_SIZE - 1)) begin
							state_q <= S_DONE;
						end else begin
							lev_q   <= lev_q + LEV_W'(1);
							state_q <= S_SMP_MUL;
						end
					end else begin
						cum_q   <= cum_n;
						c_q     <= c_q + 2'd1;
						state_q <= S_SMP_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_rate_q  <= cell_rate_q;
						out_x_q     <= (type_q == REQ_SAMPLE) ? CELL_W'(px_q) : '0;
						out_y_q     <= (type_q == REQ_SAMPLE) ? CELL_W'(py_q) : '0;
						out_total_q <= total_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_cmd.we && mem_cmd.addr == '0 |=> total_q == TOTAL_W'($past(mem_cmd.wdata)))
		else $error("root total register out of step with node memory");

	assert property (@(posedge clk) disable iff (!arst_n)
		lev_q <= LEV_W'(LOG_SIZE))
		else $error("level counter beyond tree depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || rsp.ready) |=> out_valid_q && req.ready)
		else $error("finished item not moved to output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_cmd.we |-> state_q == S_CLR || state_q == S_SET_WR)
		else $error("node memory written outside clear or update");
`endif

endmodule

`default_nettype wire
